### hdl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared widths, codes and types of the trajectory pivot selector.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int MAX_PIVOTS = 16;
  localparam int K_BITS     = 5;
  localparam int COORD_BITS = 24;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int GAP_BITS   = 2 * DIFF_BITS + 1;
  localparam int POS_BITS   = 8;
  localparam int PT_BITS    = 2 * COORD_BITS;

  localparam logic [1:0] FAULT_OK   = 2'd0;
  localparam logic [1:0] FAULT_FEW  = 2'd1;
  localparam logic [1:0] FAULT_MANY = 2'd2;

  typedef struct packed {
    logic load;   // capture |dx|, |dy| against the previous point, advance it
    logic sq_x;   // acc = dx * dx
    logic sq_y;   // acc = acc + dy * dy
  } gap_ctrl_t;

endpackage

### hdl/trajectory_pivot_selector_core.sv
// ----------------------------------------------------------------------------
// trajectory_pivot_selector_core
// Stores one trajectory, scores inner points by squared gap to the point
// before, picks the k largest and streams out first, last and picked points.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                 tlast       tuser
//  s_axis    in         point_x[23:0] point_y[47:24]       last_point  -
//  m_axis    out        pivot_x, pivot_y, pivot_position   last_pivot  fault
//  pivot_count write    5-bit k, taken on every clock edge with write enable high
//
// Load: the first point is only stored; every later point is squared for dx
// and dy in turn (one squarer is reused for both), then its gap is written to
// its RAM; a dropped point past the store depth only sets the overflow. The
// last point adds the decision state. Selection: k passes, each of n-2 gap RAM
// reads, one compare and one mark write, set by the single read port and one
// compare unit. Output: the first and the last point, then each picked point
// after a mark search over the skipped inner indexes; any stall of
// m_axis_tready holds the result. An error result is registered at the decision.
// Input is not taken until the last result has transferred. Reset clears
// control state only: each pick mark lives beside its gap and is cleared
// when the point loads, so no store entry is read before it is written.
// ----------------------------------------------------------------------------
module trajectory_pivot_selector_core import tps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pivot_count_we_i,
  input  logic [K_BITS-1:0] pivot_count_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [47:0]  s_axis_tdata_i,  // point_x[23:0], point_y[47:24]
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [55:0]  m_axis_tdata_o,  // pivot_x[23:0], pivot_y[47:24], pos[55:48]
  output logic         m_axis_tlast_o,
  output logic [1:0]   m_axis_tuser_o   // fault[1:0]
);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_SQX    = 4'd1;
  localparam logic [3:0] S_SQY    = 4'd2;
  localparam logic [3:0] S_GWR    = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_PICK   = 4'd6;
  localparam logic [3:0] S_MARK   = 4'd7;
  localparam logic [3:0] S_EFETCH = 4'd8;
  localparam logic [3:0] S_ELOAD  = 4'd9;
  localparam logic [3:0] S_EWAIT  = 4'd10;
  localparam logic [3:0] S_EFIND  = 4'd11;

  logic [3:0] state_q;
  logic [K_BITS-1:0] pivot_q, k_eff, pass_q, res_cnt_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic ovf_q, last_q, found_q, rd_vld_q, f_vld_q;
  logic [IDX_BITS-1:0] gidx_q, scan_i_q, rd_idx_q, best_q, eidx_q, find_i_q, f_idx_q;
  logic [IDX_BITS-1:0] gap_waddr, gap_raddr;
  logic [GAP_BITS-1:0] best_gap_q, gap;
  logic [GAP_BITS:0] gap_wdata, gap_rdata;  // {pick mark, gap}
  logic [PT_BITS-1:0] pt_rdata;
  logic [IDX_BITS-1:0] pt_raddr;
  logic in_xfer, out_xfer, store_ok, better, hit, gap_we;
  gap_ctrl_t gctrl;

  // output register
  logic out_vld_q, out_last_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [POS_BITS-1:0] out_pos_q;
  logic [1:0] out_fault_q;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = out_vld_q && m_axis_tready_i;
  assign store_ok = cnt_q < CNT_BITS'(MAX_POINTS);

  // clamp k into 1..MAX_PIVOTS
  always_comb begin
    priority if (pivot_q == '0) k_eff = K_BITS'(1);
    else if (pivot_q > K_BITS'(MAX_PIVOTS)) k_eff = K_BITS'(MAX_PIVOTS);
    else k_eff = pivot_q;
  end

  assign gctrl.load = (state_q == S_LOAD) && in_xfer && store_ok;
  assign gctrl.sq_x = (state_q == S_SQX);
  assign gctrl.sq_y = (state_q == S_SQY);

  tps_gap_unit u_gap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gctrl),
    .cur_x_i (s_axis_tdata_i[COORD_BITS-1:0]),
    .cur_y_i (s_axis_tdata_i[PT_BITS-1:COORD_BITS]),
    .gap_o   (gap)
  );

  tps_ram #(.WIDTH(PT_BITS), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (gctrl.load),
    .waddr_i (cnt_q[IDX_BITS-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  // a gap write from the load clears the mark, a mark write sets it
  assign gap_we    = (state_q == S_GWR) || (state_q == S_MARK);
  assign gap_waddr = (state_q == S_MARK) ? best_q : gidx_q;
  assign gap_wdata = (state_q == S_MARK) ? {1'b1, best_gap_q} : {1'b0, gap};
  // scan reads during selection, the mark search reads during output
  assign gap_raddr = (state_q == S_EFIND) ? find_i_q : scan_i_q;

  tps_ram #(.WIDTH(GAP_BITS + 1), .DEPTH(MAX_POINTS)) u_gap_ram (
    .clk_i   (clk_i),
    .we_i    (gap_we),
    .waddr_i (gap_waddr),
    .wdata_i (gap_wdata),
    .raddr_i (gap_raddr),
    .rdata_o (gap_rdata)
  );

  assign pt_raddr = eidx_q;

  // strict compare over ascending indexes: the lower index wins a tie
  assign better = !gap_rdata[GAP_BITS] &&
                  (!found_q || gap_rdata[GAP_BITS-1:0] > best_gap_q);
  // mark of the index read in the previous cycle of the search
  assign hit    = f_vld_q && gap_rdata[GAP_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q <= K_BITS'(4);
    end else if (pivot_count_we_i) begin
      pivot_q <= pivot_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      found_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      f_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      pass_q    <= '0;
      res_cnt_q <= '0;
    end else begin
      rd_vld_q <= (state_q == S_SCAN);
      f_vld_q  <= (state_q == S_EFIND);
      if (rd_vld_q && better) begin
        found_q <= 1'b1;
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            last_q <= s_axis_tlast_i;
            if (store_ok) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (store_ok && cnt_q != '0) state_q <= S_SQX;
            else if (s_axis_tlast_i) state_q <= S_DECIDE;
          end
        end
        S_SQX: state_q <= S_SQY;
        S_SQY: state_q <= S_GWR;
        S_GWR: state_q <= last_q ? S_DECIDE : S_LOAD;
        S_DECIDE: begin
          if (ovf_q || cnt_q < CNT_BITS'(k_eff) + CNT_BITS'(2)) begin
            out_vld_q <= 1'b1;
            state_q   <= S_EWAIT;
          end else begin
            pass_q  <= '0;
            found_q <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (CNT_BITS'(scan_i_q) == cnt_q - CNT_BITS'(2)) state_q <= S_PICK;
        end
        S_PICK: state_q <= S_MARK;
        S_MARK: begin
          found_q <= 1'b0;
          if (pass_q == k_eff - 1'b1) begin
            res_cnt_q <= '0;
            state_q   <= S_EFETCH;
          end else begin
            pass_q  <= pass_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_EFETCH: state_q <= S_ELOAD;
        S_ELOAD: begin
          out_vld_q <= 1'b1;
          state_q   <= S_EWAIT;
        end
        S_EWAIT: begin
          if (out_xfer) begin
            out_vld_q <= 1'b0;
            if (out_last_q) begin
              // trajectory done: drop count and overflow
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              res_cnt_q <= res_cnt_q + 1'b1;
              state_q   <= (res_cnt_q == '0) ? S_EFETCH : S_EFIND;
            end
          end
        end
        S_EFIND: begin
          if (hit) state_q <= S_EFETCH;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (gctrl.load) begin
      gidx_q <= cnt_q[IDX_BITS-1:0];
    end
    if (state_q == S_DECIDE || state_q == S_MARK) begin
      scan_i_q <= IDX_BITS'(1);
    end else if (state_q == S_SCAN) begin
      scan_i_q <= scan_i_q + 1'b1;
    end
    if (state_q == S_SCAN) begin
      rd_idx_q <= scan_i_q;
    end
    if (rd_vld_q && better) begin
      best_q     <= rd_idx_q;
      best_gap_q <= gap_rdata[GAP_BITS-1:0];
    end
    if (state_q == S_MARK) begin
      eidx_q <= '0;
    end else if (state_q == S_EWAIT && out_xfer && res_cnt_q == '0) begin
      eidx_q <= IDX_BITS'(cnt_q - 1'b1);
    end else if (state_q == S_EFIND && hit) begin
      eidx_q <= f_idx_q;
    end
    if (state_q == S_EWAIT && out_xfer) begin
      find_i_q <= (res_cnt_q == K_BITS'(1)) ? IDX_BITS'(1) : eidx_q + 1'b1;
    end else if (state_q == S_EFIND) begin
      find_i_q <= find_i_q + 1'b1;
    end
    if (state_q == S_EFIND) begin
      f_idx_q <= find_i_q;
    end
    if (state_q == S_DECIDE) begin
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b1;
      out_fault_q <= ovf_q ? FAULT_MANY : FAULT_FEW;
    end else if (state_q == S_ELOAD) begin
      out_x_q     <= pt_rdata[COORD_BITS-1:0];
      out_y_q     <= pt_rdata[PT_BITS-1:COORD_BITS];
      out_pos_q   <= POS_BITS'(eidx_q);
      out_last_q  <= (res_cnt_q == k_eff + 1'b1);
      out_fault_q <= FAULT_OK;
    end
  end

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_pos_q, out_y_q, out_x_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_fault_q;

  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MARK |-> found_q)
    else $error("pass ended with no inner point chosen");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(MAX_POINTS))
    else $error("point count past store depth");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> state_q == S_EWAIT)
    else $error("result held outside the output wait");

  a_find_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EFIND |-> CNT_BITS'(find_i_q) < cnt_q)
    else $error("mark search ran past the stored points");

endmodule

### hdl/tps_ram.sv
// ----------------------------------------------------------------------------
// tps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/tps_gap_unit.sv
// ----------------------------------------------------------------------------
// tps_gap_unit
// Squared distance to the previous point, one shared squarer over two steps.
// ----------------------------------------------------------------------------
module tps_gap_unit import tps_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gap_ctrl_t                    ctrl_i,
  input  logic signed [COORD_BITS-1:0] cur_x_i,
  input  logic signed [COORD_BITS-1:0] cur_y_i,
  output logic [GAP_BITS-1:0]          gap_o
);

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic [DIFF_BITS-1:0] dx_q, dy_q, dx_d, dy_d, op;
  logic signed [DIFF_BITS-1:0] sx, sy;
  logic [2*DIFF_BITS-1:0] prod;
  logic [GAP_BITS-1:0] acc_q;

  assign sx   = DIFF_BITS'(cur_x_i) - DIFF_BITS'(prev_x_q);
  assign sy   = DIFF_BITS'(cur_y_i) - DIFF_BITS'(prev_y_q);
  assign dx_d = sx[DIFF_BITS-1] ? DIFF_BITS'(-sx) : DIFF_BITS'(sx);
  assign dy_d = sy[DIFF_BITS-1] ? DIFF_BITS'(-sy) : DIFF_BITS'(sy);
  assign op   = ctrl_i.sq_x ? dx_q : dy_q;
  assign prod = op * op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (ctrl_i.load) begin
      prev_x_q <= cur_x_i;
      prev_y_q <= cur_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (ctrl_i.sq_x) begin
      acc_q <= GAP_BITS'(prod);
    end else if (ctrl_i.sq_y) begin
      acc_q <= acc_q + GAP_BITS'(prod);
    end
  end

  assign gap_o = acc_q;

endmodule

### bench/trajectory_pivot_selector_core_test.sv
// ----------------------------------------------------------------------------
// trajectory_pivot_selector_core_test
// Streams trajectories into the pivot selector under random gaps and stalls,
// predicts the emitted pivots (first, last, top-k gaps by index) and checks
// every output transfer field by field, across several pivot_count settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trajectory_pivot_selector_core_test;
  import tps_pkg::*;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [POS_BITS-1:0]          pos;
    logic                         last;
    logic [1:0]                   fault;
  } pivot_t;

  // Scoreboard: tracks one trajectory and queues the pivots it will emit.
  class pivot_board;
    longint            px[MAX_POINTS];
    longint            py[MAX_POINTS];
    longint unsigned   gap[MAX_POINTS];
    bit                picked[MAX_POINTS];
    int                loaded;
    bit                spilled;
    int unsigned       k_reg;
    pivot_t            pending_q[$];
    int                errors;

    function new();
      loaded  = 0;
      spilled = 0;
      k_reg   = 4;
      errors  = 0;
      foreach (picked[i]) picked[i] = 0;
    endfunction

    function void push(int idx, bit last, logic [1:0] fault);
      pivot_t p;
      if (fault != FAULT_OK) begin
        p.x = '0; p.y = '0; p.pos = '0;
      end else begin
        p.x = px[idx][COORD_BITS-1:0];
        p.y = py[idx][COORD_BITS-1:0];
        p.pos = idx[POS_BITS-1:0];
      end
      p.last  = last;
      p.fault = fault;
      pending_q.insert(pending_q.size(), p);
    endfunction

    function void clear_run();
      loaded  = 0;
      spilled = 0;
      foreach (picked[i]) picked[i] = 0;
    endfunction

    // Note an accepted point; on the last point queue what it causes.
    function void note_point(logic signed [COORD_BITS-1:0] x,
                             logic signed [COORD_BITS-1:0] y, bit last);
      longint unsigned dx, dy, sx, s;
      int k, n, best, cnt;
      bit found;
      if (loaded < MAX_POINTS) begin
        px[loaded] = longint'(x);
        py[loaded] = longint'(y);
        if (loaded == 0) begin
          gap[0] = 0;
        end else begin
          dx = (px[loaded] >= px[loaded-1]) ? px[loaded] - px[loaded-1]
                                            : px[loaded-1] - px[loaded];
          dy = (py[loaded] >= py[loaded-1]) ? py[loaded] - py[loaded-1]
                                            : py[loaded-1] - py[loaded];
          sx = dx * dx;
          s  = sx + dy * dy;
          gap[loaded] = (s < sx) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
        end
        loaded++;
      end else begin
        spilled = 1;
      end
      if (!last) return;
      k = (k_reg == 0) ? 1 : (k_reg > MAX_PIVOTS) ? MAX_PIVOTS : k_reg;
      n = loaded;
      if (spilled) begin
        push(0, 1'b1, FAULT_MANY);
      end else if (n < 2 || n - 2 < k) begin
        push(0, 1'b1, FAULT_FEW);
      end else begin
        // k passes, each takes the largest unpicked gap, lower index on ties
        for (int p = 0; p < k; p++) begin
          best = 0;
          found = 0;
          for (int i = 1; i + 1 < n; i++) begin
            if (!picked[i] && (!found || gap[i] > gap[best])) begin
              best = i;
              found = 1;
            end
          end
          if (found) picked[best] = 1;
        end
        push(0, 1'b0, FAULT_OK);
        push(n - 1, 1'b0, FAULT_OK);
        cnt = 2;
        for (int i = 1; i + 1 < n; i++) begin
          if (picked[i]) begin
            push(i, cnt == k + 1, FAULT_OK);
            cnt++;
          end
        end
      end
      clear_run();
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    // Check one output transfer against the oldest queued pivot.
    task check(logic [55:0] data, logic last, logic [1:0] fault);
      pivot_t e;
      if (pending_q.size() == 0) begin
        report("unexpected transfer pos", longint'(data[55:48]), -1);
        return;
      end
      e = pending_q.pop_front();
      if ($signed(data[23:0]) !== e.x)
        report("pivot_x", longint'($signed(data[23:0])), longint'(e.x));
      if ($signed(data[47:24]) !== e.y)
        report("pivot_y", longint'($signed(data[47:24])), longint'(e.y));
      if (data[55:48] !== e.pos)
        report("pivot_position", longint'(data[55:48]), longint'(e.pos));
      if (last !== e.last) report("last_pivot", longint'(last), longint'(e.last));
      if (fault !== e.fault) report("fault", longint'(fault), longint'(e.fault));
    endtask
  endclass

  localparam int LIMIT = 600000;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              pivot_count_we_i = 0;
  logic [K_BITS-1:0] pivot_count_i = '0;
  logic              s_axis_tvalid_i = 0;
  logic              s_axis_tready_o;
  logic [47:0]       s_axis_tdata_i = '0;  // point_x[23:0], point_y[47:24]
  logic              s_axis_tlast_i = 0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 0;
  logic [55:0]       m_axis_tdata_o;       // pivot_x, pivot_y, pivot_position
  logic              m_axis_tlast_o;
  logic [1:0]        m_axis_tuser_o;       // fault

  pivot_board board = new();
  bit         quiet;       // no idling on either side while set
  bit         hold_req;    // ask the receiver for one long hold-off
  int         cycles;

  always #5 clk_i = ~clk_i;

  trajectory_pivot_selector_core i_dut (.*);

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL trajectory_pivot_selector_core");
      $finish;
    end
  end

  // Receiver: check every transfer, then draw the stall before the next one.
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        board.check(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        stall = quiet ? 0 : $urandom_range(0, 18);
      end
      if (hold_req && m_axis_tvalid_o) begin
        // long hold-off on a waiting result so the block stalls its input
        hold_req = 0;
        stall = 400;
      end
      if (stall > 0) begin
        m_axis_tready_i <= 0;
        stall--;
      end else begin
        m_axis_tready_i <= 1;
      end
    end
  end

  // Offer one point; hold it until the transfer, then note it.
  task send_point(logic signed [23:0] x, logic signed [23:0] y, bit last);
    int gap_cycles;
    gap_cycles = quiet ? 0 : $urandom_range(0, 18);
    if (gap_cycles > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (gap_cycles) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i  <= {y, x};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_point(x, y, last);
  endtask

  // Drop valid and wait until every queued pivot has come out, then settle.
  task drain();
    s_axis_tvalid_i <= 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task write_k(logic [K_BITS-1:0] k);
    drain();
    pivot_count_we_i <= 1;
    pivot_count_i    <= k;
    @(posedge clk_i);
    pivot_count_we_i <= 0;
    board.k_reg = 32'(k);
  endtask

  function logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($signed($urandom_range(0, 7)) - 4);  // near ties
      1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Random trajectory of n points, the last one marked.
  task send_run(int n, int mode);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset k (4), too few points, exact fit, extremes, equal gaps.
    quiet = 1;
    send_point(24'sd5, -24'sd5, 1);                      // single point
    send_point(24'sd1, 24'sd2, 0);
    send_point(24'sd3, 24'sd4, 1);                       // two points
    send_point(24'sh800000, 24'sh800000, 0);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 0);
    send_point(24'sh800000, 24'sh7FFFFF, 0);
    send_point(24'sd0, 24'sd0, 0);
    send_point(24'sh7FFFFF, 24'sh800000, 0);
    send_point(-24'sd1, 24'sd1, 1);                      // n = k + 2
    write_k(5'd1);
    for (int i = 0; i < 5; i++) send_point(24'sd9, 24'sd9, i == 4);  // ties
    write_k(5'd0);                                       // zero acts as 1
    send_run(4, 0);
    write_k(5'd31);                                      // clamps to 16
    quiet = 0;
    send_run(18, 2);                                     // most results

    // Random phases over several settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_k(5'd2);
        1: write_k(5'd1);
        2: write_k(5'd3);
        default: write_k(5'($urandom_range(0, 31)));
      endcase
      quiet = (ph == 3);
      if (ph == 1) hold_req = 1;
      for (int t = 0; t < 2; t++) begin
        n = $urandom_range(2, 5);
        send_run(n, $urandom_range(0, 2));
      end
    end

    // One point too many for the store.
    write_k(5'd16);
    quiet = 1;
    send_run(MAX_POINTS + 1, 2);
    quiet = 0;

    drain();
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS trajectory_pivot_selector_core");
    end else begin
      $display("FAIL trajectory_pivot_selector_core");
    end
    $finish;
  end

endmodule
